@@ rtl/i2a_pkg.sv @@
// Shared types, codes and helpers for the integer to ASCII digit converter.
package i2a_pkg;

    localparam int POINTER_BITS_DEF = 64;
    localparam int VALUE_W          = 64;
    localparam int MODE_W           = 2;
    localparam int CHAR_W           = 8;
    localparam int QUEUE_DEPTH      = 2;
    localparam int OCT_DIGITS       = 11;

    localparam logic [MODE_W-1:0] MODE_SDEC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UDEC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OCT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HEX  = 2'd3;

    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LC_X  = 8'h78;

    // Reciprocal of ten scaled by 2**35; exact quotient for every 32-bit value.
    localparam logic [31:0] RECIP10 = 32'hcccc_cccd;
    localparam int          RECIP10_SHIFT = 35;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } base_t;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_HEX
    } pfx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXTRACT,
        ST_PREFIX,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        base_t              base;
        pfx_t               pfx;
    } item_t;

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
        begin
            c = ASCII_ZERO + {4'b0, d};
        end
        else
        begin
            c = ASCII_LC_A + {4'b0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

@@ rtl/i2a_front.sv @@
// Front end: classifies an incoming value into magnitude, base and prefix.
module i2a_front #(
    parameter int POINTER_BITS = i2a_pkg::POINTER_BITS_DEF
) (
    input  logic [i2a_pkg::MODE_W-1:0]  mode,
    input  logic [i2a_pkg::VALUE_W-1:0] value,
    output i2a_pkg::item_t              item
);
    import i2a_pkg::*;

    localparam logic [VALUE_W-1:0] PTR_MASK = {VALUE_W{1'b1}} >> (VALUE_W - POINTER_BITS);

    logic [31:0] low;

    assign low = value[31:0];

    always_comb
    begin
        item.mag  = {32'd0, low};
        item.base = BASE_DEC;
        item.pfx  = PFX_NONE;
        case (mode)
            MODE_SDEC:
            begin
                // The most negative value negates to itself, read as unsigned.
                if (low[31])
                begin
                    item.mag = {32'd0, 32'd0 - low};
                    item.pfx = PFX_MINUS;
                end
            end
            MODE_UDEC:
            begin
                item.base = BASE_DEC;
            end
            MODE_OCT:
            begin
                item.base = BASE_OCT;
            end
            MODE_HEX:
            begin
                item.mag  = value & PTR_MASK;
                item.base = BASE_HEX;
                item.pfx  = PFX_HEX;
            end
            default:
            begin
                item.base = BASE_DEC;
            end
        endcase
    end

endmodule

@@ rtl/i2a_fifo.sv @@
// Short queue of classified items between the front end and the digit engine.
module i2a_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  i2a_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output i2a_pkg::item_t pop_item
);
    import i2a_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) count_reg <= CW'(QUEUE_DEPTH);
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("queue count exceeds depth");

endmodule

@@ rtl/i2a_back.sv @@
// Digit engine: extracts digits least significant first, then emits text beats.
module i2a_back #(
    parameter int POINTER_BITS = i2a_pkg::POINTER_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  i2a_pkg::item_t             item,
    output logic                       item_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [i2a_pkg::CHAR_W-1:0] m_tdata,
    output logic                       m_tlast
);
    import i2a_pkg::*;

    localparam int HEX_DIGITS = (POINTER_BITS + 3) / 4;
    localparam int DIG_DEPTH  = (HEX_DIGITS > OCT_DIGITS) ? HEX_DIGITS : OCT_DIGITS;
    localparam int IW         = $clog2(DIG_DEPTH);
    localparam int CW         = $clog2(DIG_DEPTH + 1);

    state_t             state_reg, state_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    base_t              base_reg, base_next;
    pfx_t               pfx_reg, pfx_next;
    logic [CW-1:0]      ndig_reg, ndig_next;
    logic               pidx_reg, pidx_next;
    logic [3:0]         dig_reg [DIG_DEPTH];
    logic               dig_we;
    logic [3:0]         dig_val;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;

    logic               adv;
    logic [63:0]        prod;
    logic [31:0]        q_dec;
    logic [31:0]        rem_dec;
    logic [VALUE_W-1:0] quot;
    logic [CW-1:0]      ndig_dec;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;
    assign adv      = !out_valid_reg || m_tready;
    assign ndig_dec = ndig_reg - 1'b1;

    // One digit per cycle: decimal by reciprocal multiply, octal and hex by shifting.
    always_comb
    begin
        prod    = mag_reg[31:0] * RECIP10;
        q_dec   = 32'(prod >> RECIP10_SHIFT);
        rem_dec = mag_reg[31:0] - ((q_dec << 3) + (q_dec << 1));
        case (base_reg)
            BASE_DEC:
            begin
                dig_val = rem_dec[3:0];
                quot    = {32'd0, q_dec};
            end
            BASE_OCT:
            begin
                dig_val = {1'b0, mag_reg[2:0]};
                quot    = mag_reg >> 3;
            end
            BASE_HEX:
            begin
                dig_val = mag_reg[3:0];
                quot    = mag_reg >> 4;
            end
            default:
            begin
                dig_val = mag_reg[3:0];
                quot    = mag_reg >> 4;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        base_next      = base_reg;
        pfx_next       = pfx_reg;
        ndig_next      = ndig_reg;
        pidx_next      = pidx_reg;
        dig_we         = 1'b0;
        item_pop       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop   = 1'b1;
                    mag_next   = item.mag;
                    base_next  = item.base;
                    pfx_next   = item.pfx;
                    ndig_next  = '0;
                    pidx_next  = 1'b0;
                    state_next = ST_EXTRACT;
                end
            end
            ST_EXTRACT:
            begin
                dig_we    = 1'b1;
                ndig_next = ndig_reg + 1'b1;
                mag_next  = quot;
                if (quot == '0)
                begin
                    state_next = (pfx_reg == PFX_NONE) ? ST_EMIT : ST_PREFIX;
                end
            end
            ST_PREFIX:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b0;
                    if (pfx_reg == PFX_MINUS)
                    begin
                        out_char_next = ASCII_MINUS;
                        state_next    = ST_EMIT;
                    end
                    else if (!pidx_reg)
                    begin
                        out_char_next = ASCII_ZERO;
                        pidx_next     = 1'b1;
                    end
                    else
                    begin
                        out_char_next = ASCII_LC_X;
                        state_next    = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_ascii(dig_reg[ndig_dec[IW-1:0]]);
                    out_last_next  = (ndig_reg == CW'(1));
                    ndig_next      = ndig_dec;
                    if (ndig_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ndig_reg      <= '0;
            pidx_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ndig_reg      <= ndig_next;
            pidx_reg      <= pidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        base_reg     <= base_next;
        pfx_reg      <= pfx_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        if (dig_we)
        begin
            dig_reg[ndig_reg[IW-1:0]] <= dig_val;
        end
    end

    property p_emit_has_digits;
        @(posedge clk) disable iff (!rst_n) (state_reg == ST_EMIT) |-> (ndig_reg != '0);
    endproperty
    a_emit_has_digits: assert property (p_emit_has_digits)
        else $error("emitting with an empty digit buffer");

    property p_digit_bound;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == ST_EXTRACT) |-> (ndig_reg < CW'(DIG_DEPTH));
    endproperty
    a_digit_bound: assert property (p_digit_bound)
        else $error("digit buffer overflow");

    property p_dec_fits;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == ST_EXTRACT && base_reg == BASE_DEC) |-> (mag_reg[63:32] == '0);
    endproperty
    a_dec_fits: assert property (p_dec_fits)
        else $error("decimal magnitude wider than 32 bits");

endmodule

@@ rtl/integer_to_ascii_digits.sv @@
// Top level of the integer to ASCII digit converter.
//
// Usage: the slave stream takes one value per beat: s_tuser carries the mode
// (0 signed decimal, 1 unsigned decimal, 2 octal, 3 hex pointer with "0x")
// and s_tdata the 64-bit value, of which decimal and octal modes use the
// low 32 bits and hex mode the low POINTER_BITS bits. The master stream
// returns the text one ASCII character per beat, most significant first,
// with m_tlast on the final one. Zero prints "0" in every mode ("0x0" in
// hex mode). A classifier feeds a two-entry queue, so up to two values are
// taken while the digit engine is busy. The engine picks up a value,
// extracts one digit per cycle (a reciprocal multiply for decimal, a shift
// for octal and hex), then emits one character per cycle while m_tready
// is high.
// When the receiver stalls, the character held in the output register waits
// and the engine stops; the queue then fills and s_tready drops.
// Reset empties the queue and the output register; no text is pending after.
module integer_to_ascii_digits #(
    parameter int POINTER_BITS = i2a_pkg::POINTER_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [i2a_pkg::VALUE_W-1:0] s_tdata,  // [63:0] value
    input  logic [i2a_pkg::MODE_W-1:0]  s_tuser,  // [1:0] mode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [i2a_pkg::CHAR_W-1:0]  m_tdata,  // [7:0] character
    output logic                        m_tlast
);
    import i2a_pkg::*;

    item_t front_item;
    item_t queue_item;
    logic  queue_full;
    logic  queue_valid;
    logic  queue_pop;

    assign s_tready = !queue_full;

    i2a_front #(
        .POINTER_BITS(POINTER_BITS)
    ) u_front (
        .mode  (s_tuser),
        .value (s_tdata),
        .item  (front_item)
    );

    i2a_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_valid),
        .pop_item  (queue_item)
    );

    i2a_back #(
        .POINTER_BITS(POINTER_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queue_valid),
        .item       (queue_item),
        .item_pop   (queue_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
